@@ rtl/core/rti_pkg.sv @@
// Package with the shared types, constants and binary32 arithmetic functions.
`timescale 1ns / 1ps
package rti_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivSteps = 26;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5
  } rti_cfg_e;

  localparam logic [31:0] F_ZERO     = 32'h0000_0000;
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_EPS      = 32'h3400_0000;
  localparam logic [31:0] F_DEF_NAN  = 32'hFFC0_0000;
  localparam logic [31:0] F_QUIET    = 32'h0040_0000;

  typedef struct packed {
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] c_x;
    logic [31:0] c_y;
    logic [31:0] c_z;
  } tri_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] bary_u;
    logic [31:0] bary_v;
    logic [31:0] hit_distance;
  } res_t;

  // Values that travel alongside the reciprocal.
  typedef struct packed {
    logic        det_ok;
    logic [31:0] dsp;
    logic [31:0] dq;
    logic [31:0] deq;
  } side_t;

  function automatic logic is_nan(logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  // Normalises, rounds to nearest even and packs. The value is
  // sig_in * 2^(exp_in - 174), so a leading one at bit 47 means 1.f * 2^(exp_in-127).
  function automatic logic [31:0] round_pack(logic sgn, logic signed [11:0] exp_in,
                                             logic [47:0] sig_in);
    logic [47:0]        sig;
    logic signed [11:0] e;
    logic [5:0]         lz;
    logic               found;
    logic [47:0]        sh_sig;
    logic               lost;
    logic [11:0]        sh;
    logic [30:0]        mag;
    logic               rb;
    logic               st;
    logic               inc;
    logic [31:0]        res;
    lz    = '0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found) begin
        if (sig_in[i]) found = 1'b1;
        else lz = lz + 6'd1;
      end
    end
    sig    = sig_in << lz;
    e      = exp_in - $signed({6'd0, lz});
    sh     = '0;
    sh_sig = '0;
    lost   = 1'b0;
    mag    = '0;
    rb     = 1'b0;
    st     = 1'b0;
    inc    = 1'b0;
    if (sig_in == '0) begin
      res = {sgn, 31'd0};
    end else if (e >= 12'sd255) begin
      res = {sgn, 8'hFF, 23'd0};
    end else if (e >= 12'sd1) begin
      mag = {e[7:0], sig[46:24]};
      rb  = sig[23];
      st  = |sig[22:0];
      inc = rb & (st | mag[0]);
      res = {sgn, mag + 31'(inc)};
    end else begin
      sh = 12'(12'sd1 - e);
      if (sh > 12'd47) begin
        sh_sig = '0;
        lost   = |sig;
      end else begin
        sh_sig = sig >> sh[5:0];
        lost   = |(sig & ~({48{1'b1}} << sh[5:0]));
      end
      mag = {8'd0, sh_sig[46:24]};
      rb  = sh_sig[23];
      st  = (|sh_sig[22:0]) | lost;
      inc = rb & (st | mag[0]);
      res = {sgn, mag + 31'(inc)};
    end
    return res;
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic [23:0] ma;
    logic [23:0] mb;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [47:0] prod;
    logic        sgn;
    logic        a_zero;
    logic        b_zero;
    logic [31:0] res;
    sgn    = a[31] ^ b[31];
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    ma     = {|a[30:23], a[22:0]};
    mb     = {|b[30:23], b[22:0]};
    ea     = (a[30:23] == '0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == '0) ? 8'd1 : b[30:23];
    prod   = ma * mb;
    if (is_nan(a)) begin
      res = a | F_QUIET;
    end else if (is_nan(b)) begin
      res = b | F_QUIET;
    end else if ((is_inf(a) && b_zero) || (a_zero && is_inf(b))) begin
      res = F_DEF_NAN;
    end else if (is_inf(a) || is_inf(b)) begin
      res = {sgn, 8'hFF, 23'd0};
    end else begin
      res = round_pack(sgn, $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126, prod);
    end
    return res;
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [26:0] xm;
    logic [26:0] ym;
    logic [26:0] ys;
    logic [27:0] sum;
    logic [31:0] res;
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == '0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == '0) ? 8'd1 : y[30:23];
    d  = ex - ey;
    xm = {|x[30:23], x[22:0], 3'b000};
    ym = {|y[30:23], y[22:0], 3'b000};
    if (d >= 8'd27) begin
      ys = {26'd0, |ym};
    end else begin
      ys = (ym >> d[4:0]) | {26'd0, |(ym & ~({27{1'b1}} << d[4:0]))};
    end
    if (x[31] ^ y[31]) sum = {1'b0, xm} - {1'b0, ys};
    else sum = {1'b0, xm} + {1'b0, ys};
    if (is_nan(a)) begin
      res = a | F_QUIET;
    end else if (is_nan(b)) begin
      res = b | F_QUIET;
    end else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
      res = F_DEF_NAN;
    end else if (is_inf(a)) begin
      res = a;
    end else if (is_inf(b)) begin
      res = b;
    end else if (sum == '0) begin
      res = {x[31] & y[31], 31'd0};
    end else begin
      res = round_pack(x[31], $signed({4'd0, ex}) + 12'sd1, {sum, 20'd0});
    end
    return res;
  endfunction

  function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
    logic [31:0] res;
    if (is_nan(b)) res = fadd(a, b);
    else res = fadd(a, {~b[31], b[30:0]});
    return res;
  endfunction

  // Ordered less-than; false whenever a NaN is involved.
  function automatic logic flt(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    logic        res;
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (is_nan(a) || is_nan(b)) res = 1'b0;
    else if ((a[30:0] == '0) && (b[30:0] == '0)) res = 1'b0;
    else res = (ka < kb);
    return res;
  endfunction

endpackage

@@ rtl/core/rti_recip.sv @@
// Pipelined reciprocal of a positive binary32 value, one quotient bit per stage.
`timescale 1ns / 1ps
module rti_recip (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [31:0]    det_i,
  input  rti_pkg::side_t side_i,
  output logic           valid_o,
  output logic [31:0]    recip_o,
  output rti_pkg::side_t side_o
);
  import rti_pkg::*;

  logic [DivSteps:0] vld_q;
  logic [31:0]       det_q  [DivSteps+1];
  side_t             side_q [DivSteps+1];
  logic [23:0]       rem_q  [DivSteps+1];
  logic [25:0]       quo_q  [DivSteps+1];
  logic [24:0]       rem2   [DivSteps];
  logic [24:0]       md     [DivSteps];

  logic        out_vld_q;
  logic [31:0] out_q;
  side_t       out_side_q;
  logic [31:0] pack_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DivSteps-1:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      rem2[k] = {rem_q[k], 1'b0};
      md[k]   = {1'b0, |det_q[k][30:23], det_q[k][22:0]};
    end
  end

  // The dividend is 2^48; its leading steps leave a remainder of 2^22.
  always_ff @(posedge clk_i) begin
    det_q[0]  <= det_i;
    side_q[0] <= side_i;
    rem_q[0]  <= 24'h40_0000;
    quo_q[0]  <= '0;
    for (int k = 1; k <= DivSteps; k++) begin
      det_q[k]  <= det_q[k-1];
      side_q[k] <= side_q[k-1];
      if (rem2[k-1] >= md[k-1]) begin
        rem_q[k] <= 24'(rem2[k-1] - md[k-1]);
        quo_q[k] <= {quo_q[k-1][24:0], 1'b1};
      end else begin
        rem_q[k] <= rem2[k-1][23:0];
        quo_q[k] <= {quo_q[k-1][24:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (is_nan(det_q[DivSteps])) begin
      pack_d = det_q[DivSteps] | F_QUIET;
    end else if (is_inf(det_q[DivSteps])) begin
      pack_d = F_ZERO;
    end else begin
      pack_d = round_pack(1'b0, 12'sd254 - $signed({4'd0, det_q[DivSteps][30:23]}),
                          {quo_q[DivSteps], |rem_q[DivSteps], 21'd0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= pack_d;
    out_side_q <= side_q[DivSteps];
  end

  assign valid_o = out_vld_q;
  assign recip_o = out_q;
  assign side_o  = out_side_q;

endmodule

@@ rtl/core/ray_triangle_intersect_core.sv @@
// Top level of the pipelined single-sided ray/triangle intersection core.
`timescale 1ns / 1ps
// The core runs the Moller-Trumbore test in binary32 with round-to-nearest-even on
// every operation. The ray (origin and direction) sits in six registers written
// through the cfg port; the user must write them only while no triangle is in flight,
// and the core does not enforce this. A triangle is taken on each clock edge with start
// high (busy is never raised), so one beat per cycle is sustained. Each triangle
// yields exactly one result beat, shown on res_o with res_valid_o for a single
// cycle; the receiver cannot hold it off. The pipeline is the 28-stage reciprocal
// of the determinant (an input register, 26 bit-per-stage divider steps and a
// rounding register), plus six stages of edge, cross and dot arithmetic ahead of
// it and three stages of scaling, summing and testing after it. On a miss the
// barycentric and distance fields are zero.
module ray_triangle_intersect_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  rti_pkg::tri_t                tri_i,
  input  logic                         cfg_we_i,
  input  logic [rti_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_data_i,
  output logic                         res_valid_o,
  output rti_pkg::res_t                res_o
);
  import rti_pkg::*;

  // Ray registers.
  logic [31:0] org_q [3];
  logic [31:0] dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= F_ZERO;
        dir_q[i] <= F_ZERO;
      end
    end else if (cfg_we_i) begin
      unique case (rti_cfg_e'(cfg_idx_i))
        CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        CFG_DIR_X:    dir_q[0] <= cfg_data_i;
        CFG_DIR_Y:    dir_q[1] <= cfg_data_i;
        CFG_DIR_Z:    dir_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The core never stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // Valid bits for the stages ahead of and behind the reciprocal.
  logic [5:0] vld_q;
  logic [2:0] tail_vld_q;

  // Stage 1: edges and origin offset.
  logic [31:0] va [3];
  logic [31:0] vb [3];
  logic [31:0] vc [3];
  logic [31:0] e1_q [3];
  logic [31:0] e2_q [3];
  logic [31:0] s_q  [3];

  assign va = '{tri_i.a_x, tri_i.a_y, tri_i.a_z};
  assign vb = '{tri_i.b_x, tri_i.b_y, tri_i.b_z};
  assign vc = '{tri_i.c_x, tri_i.c_y, tri_i.c_z};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e1_q[i] <= fsub(vb[i], va[i]);
      e2_q[i] <= fsub(vc[i], va[i]);
      s_q[i]  <= fsub(org_q[i], va[i]);
    end
  end

  // Stage 2: products of the two cross products, p = dir x e2 and q = s x e1.
  logic [31:0] pm_q [6];
  logic [31:0] qm_q [6];
  logic [31:0] e1_2_q [3];
  logic [31:0] e2_2_q [3];
  logic [31:0] s_2_q  [3];

  always_ff @(posedge clk_i) begin
    pm_q[0] <= fmul(dir_q[1], e2_q[2]);
    pm_q[1] <= fmul(dir_q[2], e2_q[1]);
    pm_q[2] <= fmul(dir_q[2], e2_q[0]);
    pm_q[3] <= fmul(dir_q[0], e2_q[2]);
    pm_q[4] <= fmul(dir_q[0], e2_q[1]);
    pm_q[5] <= fmul(dir_q[1], e2_q[0]);
    qm_q[0] <= fmul(s_q[1], e1_q[2]);
    qm_q[1] <= fmul(s_q[2], e1_q[1]);
    qm_q[2] <= fmul(s_q[2], e1_q[0]);
    qm_q[3] <= fmul(s_q[0], e1_q[2]);
    qm_q[4] <= fmul(s_q[0], e1_q[1]);
    qm_q[5] <= fmul(s_q[1], e1_q[0]);
    e1_2_q  <= e1_q;
    e2_2_q  <= e2_q;
    s_2_q   <= s_q;
  end

  // Stage 3: cross product differences.
  logic [31:0] p_q [3];
  logic [31:0] q_q [3];
  logic [31:0] e1_3_q [3];
  logic [31:0] e2_3_q [3];
  logic [31:0] s_3_q  [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p_q[i] <= fsub(pm_q[2*i], pm_q[2*i+1]);
      q_q[i] <= fsub(qm_q[2*i], qm_q[2*i+1]);
    end
    e1_3_q <= e1_2_q;
    e2_3_q <= e2_2_q;
    s_3_q  <= s_2_q;
  end

  // Stage 4: the products of four dot products: e1.p, s.p, dir.q and e2.q.
  logic [31:0] dx [4][3];
  logic [31:0] dy [4][3];
  logic [31:0] dm_q [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[0][i] = e1_3_q[i];
      dy[0][i] = p_q[i];
      dx[1][i] = s_3_q[i];
      dy[1][i] = p_q[i];
      dx[2][i] = dir_q[i];
      dy[2][i] = q_q[i];
      dx[3][i] = e2_3_q[i];
      dy[3][i] = q_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) begin
        dm_q[j][i] <= fmul(dx[j][i], dy[j][i]);
      end
    end
  end

  // Stages 5 and 6: sums from left to right.
  logic [31:0] acc_q [4];
  logic [31:0] m2_q  [4];
  logic [31:0] dot_q [4];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      acc_q[j] <= fadd(dm_q[j][0], dm_q[j][1]);
      m2_q[j]  <= dm_q[j][2];
      dot_q[j] <= fadd(acc_q[j], m2_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept};
    end
  end

  // Reciprocal of the determinant; the other dot products ride along with it.
  side_t       side_in;
  side_t       side_out;
  logic        rcp_vld;
  logic [31:0] recip;

  always_comb begin
    side_in.det_ok = ~flt(dot_q[0], F_EPS);
    side_in.dsp    = dot_q[1];
    side_in.dq     = dot_q[2];
    side_in.deq    = dot_q[3];
  end

  rti_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[5]),
    .det_i   (dot_q[0]),
    .side_i  (side_in),
    .valid_o (rcp_vld),
    .recip_o (recip),
    .side_o  (side_out)
  );

  // Stage after the reciprocal: scale to u, v and t.
  logic [31:0] u_q;
  logic [31:0] v_q;
  logic [31:0] t_q;
  logic        ok_q;

  always_ff @(posedge clk_i) begin
    u_q  <= fmul(recip, side_out.dsp);
    v_q  <= fmul(recip, side_out.dq);
    t_q  <= fmul(recip, side_out.deq);
    ok_q <= side_out.det_ok;
  end

  // Next stage: u + v.
  logic [31:0] u2_q;
  logic [31:0] v2_q;
  logic [31:0] t2_q;
  logic [31:0] uv_q;
  logic        ok2_q;

  always_ff @(posedge clk_i) begin
    uv_q  <= fadd(u_q, v_q);
    u2_q  <= u_q;
    v2_q  <= v_q;
    t2_q  <= t_q;
    ok2_q <= ok_q;
  end

  // Final stage: the range tests decide the hit and zero the fields on a miss.
  logic hit_d;
  res_t res_q;

  assign hit_d = ok2_q & ~flt(u2_q, F_ZERO) & ~flt(F_ONE, u2_q) & ~flt(v2_q, F_ZERO)
               & ~flt(F_ONE, uv_q) & ~flt(t2_q, F_ZERO) & ~is_nan(t2_q);

  always_ff @(posedge clk_i) begin
    res_q.hit          <= hit_d;
    res_q.bary_u       <= hit_d ? u2_q : F_ZERO;
    res_q.bary_v       <= hit_d ? v2_q : F_ZERO;
    res_q.hit_distance <= hit_d ? t2_q : F_ZERO;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_vld_q <= '0;
    end else begin
      tail_vld_q <= {tail_vld_q[1:0], rcp_vld};
    end
  end

  assign res_valid_o = tail_vld_q[2];
  assign res_o       = res_q;

  // A miss beat carries zero in every numeric field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.hit) |->
      (res_o.bary_u == F_ZERO && res_o.bary_v == F_ZERO && res_o.hit_distance == F_ZERO))
    else $error("miss beat with non-zero fields");

  // On a hit the barycentric coordinates lie in the unit range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.hit) |->
      (!flt(F_ONE, res_o.bary_u) && !flt(F_ONE, res_o.bary_v)
       && !flt(res_o.bary_u, F_ZERO) && !flt(res_o.bary_v, F_ZERO)))
    else $error("hit beat with barycentric coordinate out of range");

  // A hit distance is never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.hit) |-> !flt(res_o.hit_distance, F_ZERO))
    else $error("hit beat with negative distance");

endmodule
